// ===== sv/minmax_upscale_2x_top_assert.svh =====
// assertion macros for the 2x min/max upscaler
// expects clk and arst_n in the scope where a macro is used
`ifndef MINMAX_UPSCALE_2X_TOP_ASSERT_SVH
`define MINMAX_UPSCALE_2X_TOP_ASSERT_SVH

// same-cycle implication
`define MMUP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MMUP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mmup2x_pkg.sv =====
// shared types, constants and channel-wise min/max for the 2x upscaler
// no dependencies
`default_nettype none

package mmup2x_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int SIZE_LIMIT    = 2048;
	localparam int SIZE_W        = 12;
	localparam int CNT_W         = 11;
	localparam int COORD_W       = 12;
	localparam int CHAN_W        = 8;
	localparam int OUT_DATA_W    = 48;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

	typedef enum logic {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

	function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
		pixel_t m;
		m.red   = (a.red   < b.red)   ? a.red   : b.red;
		m.green = (a.green < b.green) ? a.green : b.green;
		m.blue  = (a.blue  < b.blue)  ? a.blue  : b.blue;
		return m;
	endfunction

	function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
		pixel_t m;
		m.red   = (a.red   > b.red)   ? a.red   : b.red;
		m.green = (a.green > b.green) ? a.green : b.green;
		m.blue  = (a.blue  > b.blue)  ? a.blue  : b.blue;
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== sv/minmax_upscale_2x_top.sv =====
// 2x min/max image upscaler: line memory, interpolation stage, output sequencer
// depends on mmup2x_pkg and minmax_upscale_2x_top_assert.svh
`default_nettype none

// Source pixels enter in raster order; each one yields the 1 to 9 magnified
// pixels it completes, one result per cycle while the receiver does not stall,
// with tlast on the last of them: four results for an interior pixel, up to
// nine at the last row and column, all through the single output register.
// The line memory is read and written at the input transfer; the interpolation
// of the registered pixel is registered into the output sequencer as it
// advances, and each result then goes through the output register. A new
// pixel is taken while the previous one is still emitting. The line memory
// needs no clearing after reset.
module minmax_upscale_2x_top #(
	parameter int MAX_WIDTH = mmup2x_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// red_in, green_in, blue_in
	input  wire logic [23:0]                           s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// out_row, out_col, red_out, green_out, blue_out
	output logic [mmup2x_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// run_end
	output logic                                       m_axis_tlast,
	input  wire logic                                  cfg_we,
	input  wire logic                                  cfg_idx,
	input  wire logic [mmup2x_pkg::SIZE_W-1:0]         cfg_wdata
);

	`include "minmax_upscale_2x_top_assert.svh"

	localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WLIM = (MAX_WIDTH < mmup2x_pkg::SIZE_LIMIT) ?
		MAX_WIDTH : mmup2x_pkg::SIZE_LIMIT;
	localparam int SW   = mmup2x_pkg::SIZE_W;
	localparam int CW   = mmup2x_pkg::CNT_W;

	// configuration
	logic [SW-1:0] src_width_q, src_height_q;
	logic [SW-1:0] w_eff, h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= mmup2x_pkg::WIDTH_RESET;
			src_height_q <= mmup2x_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				mmup2x_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata;
				mmup2x_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (src_width_q == '0)
			w_eff = SW'(1);
		else if (src_width_q > SW'(WLIM))
			w_eff = SW'(WLIM);
		else
			w_eff = src_width_q;
		if (src_height_q == '0)
			h_eff = SW'(1);
		else if (src_height_q > SW'(mmup2x_pkg::SIZE_LIMIT))
			h_eff = SW'(mmup2x_pkg::SIZE_LIMIT);
		else
			h_eff = src_height_q;
	end

	// position counters
	logic [CW-1:0] col_q, row_q;
	logic [SW-1:0] cur_c, cur_r, nxt_c, nxt_r;
	logic          in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_comb begin
		cur_c = {1'b0, col_q};
		cur_r = {1'b0, row_q};
		if (cur_c >= w_eff) begin
			cur_c = '0;
			cur_r = cur_r + SW'(1);
		end
		if (cur_r >= h_eff)
			cur_r = '0;
		nxt_c = cur_c + SW'(1);
		nxt_r = cur_r;
		if (nxt_c >= w_eff) begin
			nxt_c = '0;
			nxt_r = cur_r + SW'(1);
			if (nxt_r >= h_eff)
				nxt_r = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			col_q <= nxt_c[CW-1:0];
			row_q <= nxt_r[CW-1:0];
		end
	end

	// line memory, read-before-write at the same address
	mmup2x_pkg::pixel_t line_mem [MAX_WIDTH];
	mmup2x_pkg::pixel_t above_q;
	logic [AW-1:0]      mem_addr;

	assign mem_addr = AW'(cur_c);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			above_q            <= line_mem[mem_addr];
			line_mem[mem_addr] <= s_axis_tdata;
		end
	end

	// stage 1: pixel and its position
	logic               s1_valid_q;
	mmup2x_pkg::pixel_t cur_s1;
	logic [CW-1:0]      r_s1, c_s1;
	logic               rlast_s1, clast_s1;
	logic               s1_adv;

	assign s_axis_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_axis_tready)
			s1_valid_q <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_s1   <= s_axis_tdata;
			r_s1     <= cur_r[CW-1:0];
			c_s1     <= cur_c[CW-1:0];
			rlast_s1 <= (cur_r == h_eff - SW'(1));
			clast_s1 <= (cur_c == w_eff - SW'(1));
		end
	end

	// neighbors carried from the previous pixel
	mmup2x_pkg::pixel_t left_q, above_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			above_left_q <= '0;
		end else if (s1_adv) begin
			left_q       <= cur_s1;
			above_left_q <= above_q;
		end
	end

	// interpolation and result mask
	mmup2x_pkg::pixel_t quad_s1 [4];
	logic [2:0]         row_en, col_en;
	logic [8:0]         mask_s1;

	always_comb begin
		quad_s1[0] = mmup2x_pkg::pix_max(mmup2x_pkg::pix_min(cur_s1, above_left_q),
			mmup2x_pkg::pix_min(left_q, above_q));
		quad_s1[1] = mmup2x_pkg::pix_min(above_q, cur_s1);
		quad_s1[2] = mmup2x_pkg::pix_min(left_q, cur_s1);
		quad_s1[3] = cur_s1;
		row_en = {rlast_s1, 1'b1, (r_s1 != '0)};
		col_en = {clast_s1, 1'b1, (c_s1 != '0)};
		for (int ri = 0; ri < 3; ri++)
			for (int ci = 0; ci < 3; ci++)
				mask_s1[ri*3+ci] = row_en[ri] && col_en[ci];
	end

	// stage 2: output sequencer
	logic               s2_valid_q;
	logic [8:0]         s2_mask_q;
	mmup2x_pkg::pixel_t quad_s2 [4];
	logic [CW-1:0]      r_s2, c_s2;
	logic [8:0]         sel, mask_rest;
	logic [1:0]         sel_r, sel_c;
	logic               out_valid_q, out_load, s2_done;

	always_comb begin
		sel       = s2_mask_q & (~s2_mask_q + 9'd1);
		mask_rest = s2_mask_q & ~sel;
		sel_r     = '0;
		sel_c     = '0;
		for (int ri = 0; ri < 3; ri++)
			for (int ci = 0; ci < 3; ci++)
				if (sel[ri*3+ci]) begin
					sel_r = 2'(ri);
					sel_c = 2'(ci);
				end
	end

	assign out_load = s2_valid_q && (!out_valid_q || m_axis_tready);
	assign s2_done  = out_load && (mask_rest == '0);
	assign s1_adv   = s1_valid_q && (!s2_valid_q || s2_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			s2_mask_q  <= '0;
		end else if (s1_adv) begin
			s2_valid_q <= 1'b1;
			s2_mask_q  <= mask_s1;
		end else if (s2_done) begin
			s2_valid_q <= 1'b0;
			s2_mask_q  <= '0;
		end else if (out_load) begin
			s2_mask_q  <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int q = 0; q < 4; q++)
				quad_s2[q] <= quad_s1[q];
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	// output register
	logic [mmup2x_pkg::COORD_W-1:0] o_row, o_col;
	mmup2x_pkg::pixel_t             o_pix;
	logic [mmup2x_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_last_q;

	always_comb begin
		o_row = {r_s2, 1'b0} + mmup2x_pkg::COORD_W'(sel_r) - mmup2x_pkg::COORD_W'(1);
		o_col = {c_s2, 1'b0} + mmup2x_pkg::COORD_W'(sel_c) - mmup2x_pkg::COORD_W'(1);
		o_pix = quad_s2[{(sel_r != 2'd0), (sel_c != 2'd0)}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {o_pix.blue, o_pix.green, o_pix.red, o_col, o_row};
			out_last_q <= (mask_rest == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// checks
	`MMUP_ASSERT_NOW(a_mask_live, s2_valid_q, s2_mask_q != '0,
		"sequencer holds a pixel with no pending results")
	`MMUP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
		"output transfer changed while stalled")
	`MMUP_ASSERT_NOW(a_last_frees, out_load && (mask_rest == '0), s2_done,
		"last result sent without freeing the sequencer")

endmodule

`default_nettype wire

// ===== dv/tb_minmax_upscale_2x_top.sv =====
// self-checking testbench for the 2x min/max upscaler: directed size and wrap cases,
// then random images under three idling mixes, with a predictor and a result queue
// depends on mmup2x_pkg and minmax_upscale_2x_top
`default_nettype none

module tb_minmax_upscale_2x_top;

	localparam int unsigned WIDTH_LIMIT =
		(mmup2x_pkg::MAX_WIDTH_DEF < mmup2x_pkg::SIZE_LIMIT) ?
		mmup2x_pkg::MAX_WIDTH_DEF : mmup2x_pkg::SIZE_LIMIT;

	typedef struct {
		logic [11:0]        row;
		logic [11:0]        col;
		mmup2x_pkg::pixel_t px;
		logic               last;
	} out_pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// red_in, green_in, blue_in
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// out_row, out_col, red_out, green_out, blue_out
	logic [47:0] m_axis_tdata;
	// run_end
	logic        m_axis_tlast;
	logic        cfg_we;
	mmup2x_pkg::reg_idx_t cfg_idx;
	logic [11:0] cfg_wdata;

	// predictor state
	logic [11:0]        size_w_q = mmup2x_pkg::WIDTH_RESET;
	logic [11:0]        size_h_q = mmup2x_pkg::HEIGHT_RESET;
	mmup2x_pkg::pixel_t line_mem [WIDTH_LIMIT];
	mmup2x_pkg::pixel_t left_px = '0;
	mmup2x_pkg::pixel_t above_left_px = '0;
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;

	out_pixel_t  pending_pixels [$];

	int unsigned src_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned sink_hold = 0;
	int unsigned pixels_sent = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;

	minmax_upscale_2x_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned eff_size(input logic [11:0] v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// per-channel min or max
	function automatic mmup2x_pkg::pixel_t chan_pick(input mmup2x_pkg::pixel_t a,
		input mmup2x_pkg::pixel_t b, input bit want_max);
		logic [23:0] x, y, z;
		x = a;
		y = b;
		for (int k = 0; k < 3; k++)
			z[8*k +: 8] = ((x[8*k +: 8] > y[8*k +: 8]) == want_max) ? x[8*k +: 8] : y[8*k +: 8];
		return z;
	endfunction

	task automatic magnify_pixel(input mmup2x_pkg::pixel_t px);
		int unsigned w, h, r, c, last_ri, last_ci;
		mmup2x_pkg::pixel_t above;
		mmup2x_pkg::pixel_t grid [3][3];
		out_pixel_t item;
		w = eff_size(size_w_q, WIDTH_LIMIT);
		h = eff_size(size_h_q, mmup2x_pkg::SIZE_LIMIT);
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;
		above = line_mem[c];
		grid[1][1] = px;
		grid[1][0] = chan_pick(left_px, px, 1'b0);
		grid[0][1] = chan_pick(above, px, 1'b0);
		grid[0][0] = chan_pick(chan_pick(px, above_left_px, 1'b0),
			chan_pick(left_px, above, 1'b0), 1'b1);
		grid[0][2] = grid[0][1];
		grid[1][2] = grid[1][1];
		for (int ci = 0; ci < 3; ci++)
			grid[2][ci] = grid[1][ci];
		last_ri = (r == h - 1) ? 2 : 1;
		last_ci = (c == w - 1) ? 2 : 1;
		for (int ri = (r > 0) ? 0 : 1; ri <= last_ri; ri++)
			for (int ci = (c > 0) ? 0 : 1; ci <= last_ci; ci++) begin
				item.row  = 12'(2 * r + ri - 1);
				item.col  = 12'(2 * c + ci - 1);
				item.px   = grid[ri][ci];
				item.last = (ri == last_ri) && (ci == last_ci);
				pending_pixels.push_back(item);
			end
		line_mem[c] = px;
		above_left_px = above;
		left_px = px;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	task automatic check_result(input logic [47:0] data, input logic last);
		out_pixel_t got, want;
		got.row  = data[11:0];
		got.col  = data[23:12];
		got.px   = data[47:24];
		got.last = last;
		results_checked++;
		if (pending_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: row %0d col %0d px %06h last %0b",
					got.row, got.col, got.px, got.last);
		end else begin
			want = pending_pixels.pop_front();
			if (got.row !== want.row || got.col !== want.col || got.px !== want.px ||
				got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected row %0d col %0d px %06h last %0b",
						want.row, want.col, want.px, want.last);
					$display("          got      row %0d col %0d px %06h last %0b",
						got.row, got.col, got.px, got.last);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata, m_axis_tlast);
	end

	// receiver: random stalls, or a counted hold-off
	always @(negedge clk) begin
		if (sink_hold != 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
		src_gap_pct = src_pct;
		sink_stall_pct = sink_pct;
	endtask

	task automatic send_pixel(input mmup2x_pkg::pixel_t px);
		@(negedge clk);
		if ($urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(0, 99) < src_gap_pct)
				@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		magnify_pixel(px);
		pixels_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input mmup2x_pkg::reg_idx_t idx, input logic [11:0] val);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mmup2x_pkg::REG_SRC_WIDTH)
			size_w_q = val;
		else
			size_h_q = val;
	endtask

	function automatic mmup2x_pkg::pixel_t random_pixel();
		logic [23:0] v;
		case ($urandom_range(0, 9))
			0: v = 24'h000000;
			1: v = 24'hFFFFFF;
			2, 3: begin
				// near-equal channels to hit ties
				v[7:0]   = 8'($urandom_range(100, 103));
				v[15:8]  = 8'($urandom_range(100, 103));
				v[23:16] = 8'($urandom_range(100, 103));
			end
			default: v = 24'($urandom_range(0, 24'hFFFFFF));
		endcase
		return v;
	endfunction

	function automatic logic [11:0] pick_size();
		case ($urandom_range(0, 19))
			0: return 12'd0;
			1, 2: return 12'($urandom_range(7, 12));
			default: return 12'($urandom_range(1, 6));
		endcase
	endfunction

	// reset size 640x480, row 0 only
	task automatic test_reset_size();
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h0F0F0F);
		send_pixel(24'hF0F0F0);
		send_pixel(24'hAA55AA);
	endtask

	// width and height shrunk below the counters mid-image
	task automatic test_width_shrink();
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'd3);
		send_pixel(24'hFF0000);
		send_pixel(24'h00FF00);
		send_pixel(24'h0000FF);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'd2);
		send_pixel(24'h123456);
		send_pixel(24'hFEDCBA);
	endtask

	// zero sizes act as 1, then a one-column image
	task automatic test_unit_sizes();
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'd0);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'd0);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'd1);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'd3);
		send_pixel(24'h80FF01);
		send_pixel(24'h7F00FE);
		send_pixel(24'hFFFFFF);
	endtask

	// oversized registers saturate, then shrink to finish
	task automatic test_size_limits();
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'hFFF);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'hFFF);
		send_pixel(24'h00FFFF);
		send_pixel(24'hFF00FF);
		send_pixel(24'hFFFF00);
		send_pixel(24'h000000);
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'd2);
		send_pixel(24'hFFFFFF);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'd1);
		send_pixel(24'h5A5A5A);
	endtask

	// 2x2 image: last pixel completes all nine neighbours
	task automatic test_full_neighbourhood();
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'd2);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'd2);
		send_pixel(24'hF0000F);
		send_pixel(24'h0FF000);
		send_pixel(24'h000FF0);
		send_pixel(24'hFFFFFF);
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_output_stall();
		write_reg(mmup2x_pkg::REG_SRC_WIDTH, 12'd5);
		write_reg(mmup2x_pkg::REG_SRC_HEIGHT, 12'd4);
		set_idling(0, 0);
		sink_hold = 400;
		for (int k = 0; k < 20; k++)
			send_pixel(random_pixel());
		drain();
	endtask

	// whole images mostly; some cut short, followed by a width that does not grow
	task automatic test_random_images(input int unsigned n_items);
		int unsigned sent, npix;
		logic [11:0] w, h;
		bit partial;
		sent = 0;
		// an earlier run may have stopped mid-image
		partial = 1'b1;
		while (sent < n_items) begin
			w = pick_size();
			h = pick_size();
			if (partial && eff_size(w, WIDTH_LIMIT) > eff_size(size_w_q, WIDTH_LIMIT))
				w = size_w_q;
			write_reg(mmup2x_pkg::REG_SRC_WIDTH, w);
			write_reg(mmup2x_pkg::REG_SRC_HEIGHT, h);
			npix = eff_size(w, WIDTH_LIMIT) * eff_size(h, mmup2x_pkg::SIZE_LIMIT);
			if (npix <= 20)
				npix = npix * $urandom_range(1, 3);
			partial = ($urandom_range(0, 5) == 0);
			if (partial)
				npix = $urandom_range(1, npix);
			if (npix > n_items - sent) begin
				npix = n_items - sent;
				partial = 1'b1;
			end
			for (int k = 0; k < npix; k++)
				send_pixel(random_pixel());
			sent += npix;
			drain();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_idx       = mmup2x_pkg::REG_SRC_WIDTH;
		cfg_wdata     = '0;
		foreach (line_mem[i])
			line_mem[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idling(28, 87);
		test_reset_size();
		test_width_shrink();
		test_unit_sizes();
		test_size_limits();
		test_full_neighbourhood();
		test_output_stall();

		set_idling(28, 87);
		test_random_images(95);
		set_idling(87, 28);
		test_random_images(95);
		set_idling(0, 0);
		test_random_images(95);

		drain();
		repeat (12) @(posedge clk);

		$display("covered sizes 1x1 to saturated, mid-image wraps, output hold-off,");
		$display("three idling mixes: %0d source pixels in, %0d magnified pixels checked",
			pixels_sent, results_checked);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/mmup2x_pkg.sv
sv/minmax_upscale_2x_top.sv
dv/tb_minmax_upscale_2x_top.sv
